### rtl/core/bdqs_pkg.sv
// types and codes shared by the bounded deque with search
// no dependencies

package bdqs_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_SEARCH     = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         item_count;
    logic               is_empty;
    logic               found;
    logic [1:0]         status;
  } rsp_t;

  // one-hot operation broadcast to every cell
  typedef struct packed {
    logic add_back;
    logic add_front;
    logic drop_back;
    logic drop_front;
    logic search;
    logic clear;
  } cell_cmd_t;

endpackage

### rtl/core/bdqs_cell.sv
// one slot of the deque chain: value, valid bit and search match flag
// depends on bdqs_pkg for the cell command struct

module bdqs_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bdqs_pkg::cell_cmd_t      cmd_i,
  input  logic [DATA_WIDTH-1:0]    wdata_i,
  input  logic [DATA_WIDTH-1:0]    left_val_i,
  input  logic                     left_vld_i,
  input  logic [DATA_WIDTH-1:0]    right_val_i,
  input  logic                     right_vld_i,
  output logic [DATA_WIDTH-1:0]    val_o,
  output logic                     vld_o,
  output logic                     last_o,
  output logic                     match_o
);

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  vld_q, vld_d;
  logic                  match_q, match_d;

  always_comb begin
    val_d   = val_q;
    vld_d   = vld_q;
    match_d = 1'b0;
    if (cmd_i.clear) begin
      vld_d = 1'b0;
    end else if (cmd_i.add_front) begin
      // whole row moves one slot toward the back
      val_d = left_val_i;
      vld_d = left_vld_i;
    end else if (cmd_i.drop_front) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (cmd_i.add_back) begin
      // first empty slot behind a filled one takes the beat
      if (!vld_q && left_vld_i) begin
        val_d = wdata_i;
        vld_d = 1'b1;
      end
    end else if (cmd_i.drop_back) begin
      if (vld_q && !right_vld_i) begin
        vld_d = 1'b0;
      end
    end else if (cmd_i.search) begin
      match_d = vld_q && (val_q == wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign vld_o   = vld_q;
  assign last_o  = vld_q && !right_vld_i;
  assign match_o = match_q;

endmodule

### rtl/core/bounded_deque_with_search.sv
// top level of the bounded deque with search: a row of bdqs_cell slots
// depends on bdqs_pkg and bdqs_cell
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------
//  request  | start / busy       | req_i  (bdqs_pkg::req_t)
//  response | done_o strobe      | rsp_o  (bdqs_pkg::rsp_t)
//
// a beat is taken when start is high and busy is low; the response strobes
// from done_q, behind pend_q, for exactly one cycle and cannot be held off
// a new beat waits until busy drops: the cell row updates on the accepting edge,
// then front, back-value and match reductions over the row are registered in rsp_q
// busy is high only in the cycle after an accepted beat
// reset clears all valid bits, the count and the response strobe

module bounded_deque_with_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bdqs_pkg::req_t       req_i,
  output logic                 done_o,
  output bdqs_pkg::rsp_t       rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] val   [DEPTH];
  logic [DEPTH-1:0]      vld;
  logic [DEPTH-1:0]      last;
  logic [DEPTH-1:0]      match;

  logic [DATA_WIDTH-1:0] wdata;
  logic                  accept;
  logic                  full, empty;
  bdqs_pkg::cell_cmd_t   cmd;
  logic [1:0]            stat_d;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pend_q;
  logic [1:0]            stat_q;
  logic                  srch_q;
  logic                  done_q;
  bdqs_pkg::rsp_t        rsp_q, rsp_d;

  assign accept = start && !busy;
  assign wdata  = DATA_WIDTH'($unsigned(req_i.data_value));
  assign full   = vld[DEPTH-1];
  assign empty  = !vld[0];

  // decode, with full and empty guards applied before the row sees it
  always_comb begin
    cmd    = '0;
    stat_d = bdqs_pkg::ST_OK;
    cnt_d  = cnt_q;
    if (accept) begin
      case (req_i.action)
        bdqs_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            stat_d = bdqs_pkg::ST_FULL;
          end else begin
            cmd.add_back = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        bdqs_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            stat_d = bdqs_pkg::ST_FULL;
          end else begin
            cmd.add_front = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        bdqs_pkg::ACT_POP_BACK: begin
          if (empty) begin
            stat_d = bdqs_pkg::ST_EMPTY;
          end else begin
            cmd.drop_back = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end
        end
        bdqs_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            stat_d = bdqs_pkg::ST_EMPTY;
          end else begin
            cmd.drop_front = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end
        end
        bdqs_pkg::ACT_SEARCH: begin
          cmd.search = 1'b1;
        end
        bdqs_pkg::ACT_CLEAR: begin
          cmd.clear = 1'b1;
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lval, rval;
    logic                  lvld, rvld;

    if (i == 0) begin : g_head
      assign lval = wdata;
      assign lvld = 1'b1;
    end else begin : g_mid
      assign lval = val[i-1];
      assign lvld = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rval = val[i+1];
      assign rvld = vld[i+1];
    end

    bdqs_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .wdata_i     (wdata),
      .left_val_i  (lval),
      .left_vld_i  (lvld),
      .right_val_i (rval),
      .right_vld_i (rvld),
      .val_o       (val[i]),
      .vld_o       (vld[i]),
      .last_o      (last[i]),
      .match_o     (match[i])
    );
  end

  // and-or reductions over the row for the response
  always_comb begin
    logic [DATA_WIDTH-1:0] back;
    back = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back = back | (last[i] ? val[i] : '0);
    end
    rsp_d.front_value = vld[0] ? 32'(val[0]) : '0;
    rsp_d.back_value  = 32'(back);
    rsp_d.item_count  = 5'(cnt_q);
    rsp_d.is_empty    = !vld[0];
    rsp_d.found       = srch_q && (|match);
    rsp_d.status      = stat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      stat_q <= bdqs_pkg::ST_OK;
      srch_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= accept;
      done_q <= pend_q;
      if (accept) begin
        stat_q <= stat_d;
        srch_q <= cmd.search;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = pend_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  // valid bits of the row must track the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == cnt_q)
    else $error("valid bits disagree with count");

  // filled slots form a single unbroken run in the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(last))
    else $error("more than one back slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> done_q)
    else $error("response strobe missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (req_i.action == bdqs_pkg::ACT_PUSH_BACK ||
                       req_i.action == bdqs_pkg::ACT_PUSH_FRONT)
    |=> stat_q == bdqs_pkg::ST_FULL && $stable(cnt_q))
    else $error("push on full store not rejected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.found |-> rsp_q.status == bdqs_pkg::ST_OK)
    else $error("match reported with error status");
`endif

endmodule

### dv/bdqs_checker.sv
// checker for the bounded deque with search: predicts every response from the
// accepted request beats and compares it field by field with what the dut reports
// depends on bdqs_pkg
`timescale 1ns / 100ps

module bdqs_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  bdqs_pkg::req_t      req_i,
  input  logic                done_i,
  input  bdqs_pkg::rsp_t      rsp_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int DEPTH = 16;

  // shadow copy of the ring
  logic [31:0] ring_slots [DEPTH];
  logic [3:0]  ring_head;
  logic [4:0]  ring_count;

  bdqs_pkg::rsp_t rsp_expected_q [$];
  bdqs_pkg::rsp_t rsp_want;
  int             mismatch_total;

  function automatic bdqs_pkg::rsp_t deque_apply(input bdqs_pkg::req_t beat);
    bdqs_pkg::rsp_t    res;
    bdqs_pkg::status_e st;
    logic              hit;
    logic [3:0]        idx;
    res = '0;
    st  = bdqs_pkg::ST_OK;
    hit = 1'b0;
    case (bdqs_pkg::action_e'(beat.action))
      bdqs_pkg::ACT_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          st = bdqs_pkg::ST_FULL;
        end else begin
          idx = ring_head + ring_count[3:0];
          ring_slots[idx] = beat.data_value;
          ring_count++;
        end
      end
      bdqs_pkg::ACT_PUSH_FRONT: begin
        if (ring_count == DEPTH) begin
          st = bdqs_pkg::ST_FULL;
        end else begin
          ring_head = ring_head - 4'd1;
          ring_slots[ring_head] = beat.data_value;
          ring_count++;
        end
      end
      bdqs_pkg::ACT_POP_BACK: begin
        if (ring_count == 0) st = bdqs_pkg::ST_EMPTY;
        else ring_count--;
      end
      bdqs_pkg::ACT_POP_FRONT: begin
        if (ring_count == 0) begin
          st = bdqs_pkg::ST_EMPTY;
        end else begin
          ring_head = ring_head + 4'd1;
          ring_count--;
        end
      end
      bdqs_pkg::ACT_SEARCH: begin
        for (int i = 0; i < DEPTH; i++) begin
          idx = ring_head + 4'(i);
          if (i < ring_count && ring_slots[idx] == beat.data_value) hit = 1'b1;
        end
      end
      bdqs_pkg::ACT_CLEAR: begin
        ring_head  = '0;
        ring_count = '0;
      end
      default: ;  // undefined actions leave everything alone
    endcase
    if (ring_count != 0) begin
      res.front_value = ring_slots[ring_head];
      idx = ring_head + ring_count[3:0] - 4'd1;
      res.back_value = ring_slots[idx];
    end
    res.item_count = ring_count;
    res.is_empty   = (ring_count == 0);
    res.found      = hit;
    res.status     = st;
    return res;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%h actual 0x%h", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head  = '0;
      ring_count = '0;
      rsp_expected_q.delete();
      mismatch_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // a response always belongs to an older beat, so compare before predicting
      if (done_i) begin
        if (rsp_expected_q.size() == 0) begin
          $display("%0t: response with nothing expected: expected none actual 0x%h",
                   $time, rsp_i);
          mismatch_total++;
        end else begin
          rsp_want = rsp_expected_q[0];
          rsp_expected_q.delete(0);
          flag_field("front_value", rsp_want.front_value, rsp_i.front_value);
          flag_field("back_value", rsp_want.back_value, rsp_i.back_value);
          flag_field("item_count", 32'(rsp_want.item_count), 32'(rsp_i.item_count));
          flag_field("is_empty", 32'(rsp_want.is_empty), 32'(rsp_i.is_empty));
          flag_field("found", 32'(rsp_want.found), 32'(rsp_i.found));
          flag_field("status", 32'(rsp_want.status), 32'(rsp_i.status));
        end
      end
      if (start_i && !busy_i) begin
        rsp_expected_q.insert(rsp_expected_q.size(), deque_apply(req_i));
      end
      pending_o    <= rsp_expected_q.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

### dv/tb_bounded_deque_with_search.sv
// testbench top for the bounded deque with search: clock, reset, request
// stimulus and the verdict; depends on bdqs_pkg, bounded_deque_with_search and bdqs_checker
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;

  // action codes the package leaves undefined
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;
  localparam int RANDOM_BEATS = 900;
  localparam int QUIET_TAIL   = 100;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  logic           done;
  bdqs_pkg::req_t req;
  bdqs_pkg::rsp_t rsp;
  int             fail_count;
  int             pending;

  logic [31:0] value_pool [8] = '{32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                                  32'h1, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff};
  logic [31:0] recent_pushes [8];
  int          recent_wr;

  bounded_deque_with_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  bdqs_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 3) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // holds start high until the beat is taken; start stays high for a following beat
  task automatic send_beat(input logic [2:0] act, input logic [31:0] val);
    req   <= '{action: act, data_value: val};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (act == bdqs_pkg::ACT_PUSH_BACK || act == bdqs_pkg::ACT_PUSH_FRONT) begin
      recent_pushes[recent_wr % 8] = val;
      recent_wr++;
    end
  endtask

  task automatic hold_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int         mode;
    int         roll;
    logic [2:0] act;
    logic [31:0] val;
    start     <= 1'b0;
    req       <= '0;
    rst_ni    <= 1'b0;
    recent_wr  = 0;
    for (int i = 0; i < 8; i++) recent_pushes[i] = value_pool[i];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pops and search on an empty store, undefined actions
    send_beat(bdqs_pkg::ACT_POP_BACK, 32'h0);
    send_beat(bdqs_pkg::ACT_POP_FRONT, 32'hffffffff);
    send_beat(bdqs_pkg::ACT_SEARCH, 32'h0);
    send_beat(ACT_RSVD_6, 32'h12345678);
    send_beat(ACT_RSVD_7, 32'hedcba987);
    // single element, popped from the back and from the front
    send_beat(bdqs_pkg::ACT_PUSH_BACK, 32'h80000000);
    send_beat(bdqs_pkg::ACT_SEARCH, 32'h80000000);
    send_beat(bdqs_pkg::ACT_SEARCH, 32'h7fffffff);
    send_beat(bdqs_pkg::ACT_POP_BACK, 32'h0);
    send_beat(bdqs_pkg::ACT_PUSH_FRONT, 32'h7fffffff);
    send_beat(bdqs_pkg::ACT_POP_FRONT, 32'h0);
    // fill from both ends, then push on full
    for (int i = 0; i < 16; i++)
      send_beat(i[0] ? bdqs_pkg::ACT_PUSH_FRONT : bdqs_pkg::ACT_PUSH_BACK,
                value_pool[i % 8] ^ 32'(i << 8));
    send_beat(bdqs_pkg::ACT_PUSH_BACK, 32'h7fffffff);
    send_beat(bdqs_pkg::ACT_PUSH_FRONT, 32'h80000000);
    send_beat(bdqs_pkg::ACT_SEARCH, value_pool[5] ^ 32'(5 << 8));
    send_beat(bdqs_pkg::ACT_CLEAR, 32'h0);

    mode = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // phases lean toward filling, draining, mixing or searching
      if (n % 30 == 0) mode = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        act = $urandom_range(0, 1) ? ACT_RSVD_7 : ACT_RSVD_6;
      end else if (roll < 4) begin
        act = bdqs_pkg::ACT_CLEAR;
      end else if (roll < (mode == 3 ? 44 : 19)) begin
        act = bdqs_pkg::ACT_SEARCH;
      end else if ($urandom_range(0, 99) < (mode == 0 ? 75 : (mode == 1 ? 25 : 50))) begin
        act = $urandom_range(0, 1) ? bdqs_pkg::ACT_PUSH_FRONT : bdqs_pkg::ACT_PUSH_BACK;
      end else begin
        act = $urandom_range(0, 1) ? bdqs_pkg::ACT_POP_FRONT : bdqs_pkg::ACT_POP_BACK;
      end
      if (act == bdqs_pkg::ACT_SEARCH && $urandom_range(0, 9) < 6)
        val = recent_pushes[$urandom_range(0, 7)];
      else
        val = pick_value();
      send_beat(act, val);
      if (n == RANDOM_BEATS / 2) drain_responses();
      else if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 5) == 0)
        hold_sender($urandom_range(1, 12));
    end

    drain_responses();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
